// ===== sv/status_line_parser_with_timeout_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef STATUS_LINE_PARSER_WITH_TIMEOUT_CORE_MACROS_SVH
`define STATUS_LINE_PARSER_WITH_TIMEOUT_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SLPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SLPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/slpt_pkg.sv =====
`default_nettype none

package slpt_pkg;

  localparam int unsigned LineDepthDef = 40;
  localparam int unsigned NumReadings  = 6;

  localparam logic [15:0] TimeoutRst = 16'd3000;
  localparam logic [15:0] ErrValue   = 16'hFFFF;

  // APB register indexes
  localparam logic RegTimeoutIdx = 1'b0;

  typedef enum logic {
    KindByte = 1'b0,
    KindTick = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e  item_kind;
    logic [7:0]  byte_value;
  } in_word_t;

  typedef struct packed {
    logic [15:0] voltage_reading;
    logic [15:0] current_reading;
    logic [15:0] voltage_limit_reading;
    logic [15:0] current_limit_reading;
    logic [15:0] power_limit_reading;
    logic [15:0] status_reading;
    logic        poll_request;
    logic        timed_out;
  } out_word_t;

endpackage

`default_nettype wire

// ===== sv/status_line_parser_with_timeout_core.sv =====
// Status line parser with poll timeout.
// Input channel (in_valid_i / in_stall_o, in_word_i): one word is either a
// received byte of the supply's ASCII status line or a millisecond tick.
// Bytes fill a line store; a line feed ends the line and marks it pending.
// Bytes never produce an output word.
// Output channel (out_valid_o / out_stall_i, out_word_o): every tick produces
// exactly one word holding the six readings after that tick, a poll request
// flag and a timeout flag.
// Timing: an accepted tick shows on out_word_o after its edge if the output
// register is free. One word per cycle (bytes or ticks) while not stalled.
// Stalls: the output register is backed by a one-entry skid register, so one
// more tick is taken while a result waits; in_stall_o rises only once the
// skid register is full and is a pure register output.
// Reset: line store, readings and counters clear, timeout_ticks returns to
// 3000, both channels come up empty.
// Config: APB register 0 (byte address 0) holds timeout_ticks in bits 15:0.
`default_nettype none

module status_line_parser_with_timeout_core
  import slpt_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = LineDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire in_word_t    in_word_i,
  // output channel
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      out_word_t   out_word_o,
  // APB config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int unsigned PosW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(LINE_DEPTH);
  localparam logic [PosW-1:0] DepthPos = PosW'(LINE_DEPTH);

  localparam logic [7:0] LfChar    = 8'h0A;
  localparam logic [7:0] CrChar    = 8'h0D;
  localparam logic [7:0] DigitBase = 8'h30;
  localparam logic [7:0] TagV = 8'h56;  // 'V'
  localparam logic [7:0] TagA = 8'h41;  // 'A'
  localparam logic [7:0] TagU = 8'h55;  // 'U'
  localparam logic [7:0] TagI = 8'h49;  // 'I'
  localparam logic [7:0] TagP = 8'h50;  // 'P'
  localparam logic [7:0] TagF = 8'h46;  // 'F'

  // ---------------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------------
  logic [15:0] timeout_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegTimeoutIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
    end else if (cfg_wr) begin
      timeout_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegTimeoutIdx) begin
      prdata = {16'd0, timeout_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic      out_valid_q, skid_valid_q;
  out_word_t out_q, skid_q;
  logic      in_acc, byte_acc, tick_acc;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign byte_acc   = in_acc && (in_word_i.item_kind == KindByte);
  assign tick_acc   = in_acc && (in_word_i.item_kind == KindTick);

  // ---------------------------------------------------------------------------
  // Line store: flops, each read at its fixed decode position
  // ---------------------------------------------------------------------------
  logic [7:0]      line_q [LINE_DEPTH];
  logic [PosW-1:0] wpos_q, wpos_d;
  logic            pending_q, pending_d;
  logic            store_full, store_we, is_lf;

  assign store_full = (wpos_q >= DepthPos);
  assign is_lf      = (in_word_i.byte_value == LfChar);
  // a line feed is stored too when there is room
  assign store_we   = byte_acc && !store_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line_q[i] <= '0;
      end
    end else if (store_we) begin
      line_q[wpos_q[IdxW-1:0]] <= in_word_i.byte_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Tick handling: decode a pending line or run the idle counter
  // ---------------------------------------------------------------------------
  logic [7:0]  dig [LINE_DEPTH];
  logic [15:0] rd_q [NumReadings];
  logic [15:0] rd_d [NumReadings];
  logic [15:0] idle_q, idle_d;
  logic [16:0] idle_inc;
  logic        idle_over, line_ended, poll, tout;

  always_comb begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      dig[i] = line_q[i] - DigitBase;
    end
  end

  assign line_ended = (line_q[37] == CrChar) || (line_q[38] == CrChar);
  assign idle_inc   = {1'b0, idle_q} + 17'd1;
  assign idle_over  = idle_inc > {1'b0, timeout_q};

  always_comb begin
    wpos_d    = wpos_q;
    pending_d = pending_q;
    idle_d    = idle_q;
    poll      = 1'b0;
    tout      = 1'b0;
    for (int i = 0; i < NumReadings; i++) begin
      rd_d[i] = rd_q[i];
    end

    if (byte_acc) begin
      if (is_lf) begin
        wpos_d    = '0;
        pending_d = 1'b1;
      end else if (!store_full) begin
        wpos_d = wpos_q + PosW'(1);
      end
    end

    if (tick_acc) begin
      if (pending_q) begin
        poll      = 1'b1;
        pending_d = 1'b0;
        idle_d    = '0;
        if (line_ended) begin
          if (line_q[0] == TagV) begin
            rd_d[0] = 16'(dig[1]) * 16'd10000 + 16'(dig[2]) * 16'd1000
                    + 16'(dig[4]) * 16'd100   + 16'(dig[5]) * 16'd10;
          end
          if (line_q[6] == TagA) begin
            rd_d[1] = 16'(dig[7]) * 16'd1000 + 16'(dig[9]) * 16'd100
                    + 16'(dig[10]) * 16'd10  + 16'(dig[11]);
          end
          if (line_q[18] == TagU) begin
            rd_d[2] = 16'(dig[19]) * 16'd10 + 16'(dig[20]);
          end
          if (line_q[21] == TagI) begin
            rd_d[3] = 16'(dig[22]) * 16'd1000 + 16'(dig[24]) * 16'd100
                    + 16'(dig[25]) * 16'd10;
          end
          if (line_q[26] == TagP) begin
            rd_d[4] = 16'(dig[27]) * 16'd100 + 16'(dig[28]) * 16'd10
                    + 16'(dig[29]);
          end
          if (line_q[30] == TagF) begin
            rd_d[5] = 16'(dig[31]);
          end
        end
      end else if (idle_over) begin
        poll   = 1'b1;
        tout   = 1'b1;
        idle_d = '0;
        for (int i = 0; i < NumReadings; i++) begin
          rd_d[i] = ErrValue;
        end
      end else begin
        idle_d = idle_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q    <= '0;
      pending_q <= 1'b0;
      idle_q    <= '0;
      for (int i = 0; i < NumReadings; i++) begin
        rd_q[i] <= '0;
      end
    end else begin
      wpos_q    <= wpos_d;
      pending_q <= pending_d;
      idle_q    <= idle_d;
      for (int i = 0; i < NumReadings; i++) begin
        rd_q[i] <= rd_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result word, output register and skid register
  // ---------------------------------------------------------------------------
  out_word_t res;
  logic      out_load, out_valid_d, skid_valid_d;

  always_comb begin
    res.voltage_reading       = rd_d[0];
    res.current_reading       = rd_d[1];
    res.voltage_limit_reading = rd_d[2];
    res.current_limit_reading = rd_d[3];
    res.power_limit_reading   = rd_d[4];
    res.status_reading        = rd_d[5];
    res.poll_request          = poll;
    res.timed_out             = tout;
  end

  // output register may take a new word when empty or being drained
  assign out_load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_load) begin
      out_valid_d  = skid_valid_q || tick_acc;
      skid_valid_d = 1'b0;
    end else if (tick_acc) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (tick_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/slpt_checker.sv =====
`default_nettype none

`include "status_line_parser_with_timeout_core_macros.svh"

module slpt_checker
  import slpt_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_word_t out_word_o
);

  logic all_err;

  assign all_err = (out_word_o.voltage_reading == ErrValue)
                && (out_word_o.current_reading == ErrValue)
                && (out_word_o.voltage_limit_reading == ErrValue)
                && (out_word_o.current_limit_reading == ErrValue)
                && (out_word_o.power_limit_reading == ErrValue)
                && (out_word_o.status_reading == ErrValue);

  // a timeout always comes with a poll request
  `SLPT_ASSERT(a_tout_polls, out_valid_o && out_word_o.timed_out |-> out_word_o.poll_request, "timeout without poll")

  // a timeout forces every reading to the error value
  `SLPT_ASSERT(a_tout_err, out_valid_o && out_word_o.timed_out |-> all_err, "timeout readings wrong")

  // input back-pressure only after the output was held
  `SLPT_ASSERT(a_stall_cause, in_stall_o |-> $past(out_valid_o && out_stall_i), "stall without cause")

  // a held output word stays put
  `SLPT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o), "held word changed")

endmodule

bind status_line_parser_with_timeout_core slpt_checker u_slpt_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

// Self-checking bench for the status line parser.
// The driver pushes words (line bytes and millisecond ticks) from a queue that
// the stimulus process fills; the monitor checks every result word against a
// behavioral predictor that runs on each accepted input word.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slpt_pkg::*;

  localparam int unsigned LineDepth = LineDepthDef;

  // line framing and decoding constants
  localparam logic [7:0] LfChar    = 8'h0A;
  localparam logic [7:0] CrChar    = 8'h0D;
  localparam logic [7:0] DigitBase = 8'h30;
  localparam logic [7:0] TagVolt   = "V";
  localparam logic [7:0] TagCurr   = "A";
  localparam logic [7:0] TagVLim   = "U";
  localparam logic [7:0] TagILim   = "I";
  localparam logic [7:0] TagPLim   = "P";
  localparam logic [7:0] TagStat   = "F";
  localparam int PosVolt = 0;
  localparam int PosCurr = 6;
  localparam int PosVLim = 18;
  localparam int PosILim = 21;
  localparam int PosPLim = 26;
  localparam int PosStat = 30;
  localparam int PosCrA  = 37;
  localparam int PosCrB  = 38;
  localparam int NoCr    = -1;
  // short line that still covers every field, ends before the CR positions
  localparam int ShortLen = PosStat + 2;

  // config register byte addresses
  localparam logic [2:0] TimeoutAddr = {RegTimeoutIdx, 2'b00};
  localparam logic [2:0] UnusedAddr  = 3'd4;

  localparam int SettleCycles = 4;
  localparam int HoldCycles   = 64;
  localparam int HoldEvery    = 16;

  // how the digit positions of a generated line get filled
  typedef enum int {
    DigitsRandom,
    DigitsNine,
    DigitsZero,
    DigitsNul,
    DigitsFF,
    DigitsAny
  } digit_mode_e;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  status_line_parser_with_timeout_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // words waiting to be sent, and results the predictor says must come back
  in_word_t  tx_words[$];
  out_word_t expected_reports[$];

  int send_idle_pct = 29;
  int recv_idle_pct = 54;
  int mismatch_cnt  = 0;
  int reports_seen  = 0;
  int next_hold_at  = 1;
  int hold_left     = 0;
  int words_queued  = 0;
  int ticks_queued  = 0;

  // ---------------------------------------------------------------------
  // Predictor state: line store, write pointer, pending flag, idle tick
  // counter, the current readings and the timeout setting.
  // ---------------------------------------------------------------------
  logic [7:0]  line_buf[LineDepth];
  int unsigned wr_pos      = 0;
  bit          line_ready  = 1'b0;
  int unsigned idle_cnt    = 0;
  out_word_t   readings_now = '0;
  logic [15:0] timeout_cfg = TimeoutRst;

  initial begin
    for (int i = 0; i < LineDepth; i++) line_buf[i] = '0;
  end

  // digit value at a line position: byte minus '0', wrapping in 8 bits
  function automatic int unsigned digit_at(int p);
    logic [7:0] d;
    d = line_buf[p] - DigitBase;
    return {24'd0, d};
  endfunction

  // Decode the stored line; a field only moves when its tag is in place and
  // the line carries a CR at one of the two end positions.
  task automatic decode_line();
    if (line_buf[PosCrA] != CrChar && line_buf[PosCrB] != CrChar) return;
    if (line_buf[PosVolt] == TagVolt)
      readings_now.voltage_reading = 16'(digit_at(1) * 10000 + digit_at(2) * 1000 +
                                         digit_at(4) * 100 + digit_at(5) * 10);
    if (line_buf[PosCurr] == TagCurr)
      readings_now.current_reading = 16'(digit_at(7) * 1000 + digit_at(9) * 100 +
                                         digit_at(10) * 10 + digit_at(11));
    if (line_buf[PosVLim] == TagVLim)
      readings_now.voltage_limit_reading = 16'(digit_at(19) * 10 + digit_at(20));
    if (line_buf[PosILim] == TagILim)
      readings_now.current_limit_reading = 16'(digit_at(22) * 1000 + digit_at(24) * 100 +
                                               digit_at(25) * 10);
    if (line_buf[PosPLim] == TagPLim)
      readings_now.power_limit_reading = 16'(digit_at(27) * 100 + digit_at(28) * 10 +
                                             digit_at(29));
    if (line_buf[PosStat] == TagStat)
      readings_now.status_reading = 16'(digit_at(31));
  endtask

  // Advance the predictor by one accepted word; ticks queue one result.
  task automatic track_status_line(input in_word_t w);
    if (w.item_kind == KindByte) begin
      if (w.byte_value == LfChar) begin
        // LF lands in the store only if there is room, but always ends the line
        if (wr_pos < LineDepth) line_buf[wr_pos] = w.byte_value;
        wr_pos     = 0;
        line_ready = 1'b1;
      end else if (wr_pos < LineDepth) begin
        line_buf[wr_pos] = w.byte_value;
        wr_pos++;
      end
      // full store: byte dropped until the next LF
    end else begin
      readings_now.poll_request = 1'b0;
      readings_now.timed_out    = 1'b0;
      if (line_ready) begin
        decode_line();
        readings_now.poll_request = 1'b1;
        line_ready = 1'b0;
        idle_cnt   = 0;
      end else if (idle_cnt + 1 > timeout_cfg) begin
        readings_now.voltage_reading       = ErrValue;
        readings_now.current_reading       = ErrValue;
        readings_now.voltage_limit_reading = ErrValue;
        readings_now.current_limit_reading = ErrValue;
        readings_now.power_limit_reading   = ErrValue;
        readings_now.status_reading        = ErrValue;
        readings_now.poll_request = 1'b1;
        readings_now.timed_out    = 1'b1;
        idle_cnt = 0;
      end else begin
        idle_cnt++;
      end
      expected_reports.push_back(readings_now);
    end
  endtask

  task automatic flag_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic compare_report(input out_word_t got);
    out_word_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: result word with nothing expected, expected none, actual %h",
               $time, got);
      mismatch_cnt++;
      return;
    end
    want = expected_reports.pop_front();
    flag_field("voltage_reading", want.voltage_reading, got.voltage_reading);
    flag_field("current_reading", want.current_reading, got.current_reading);
    flag_field("voltage_limit_reading", want.voltage_limit_reading,
               got.voltage_limit_reading);
    flag_field("current_limit_reading", want.current_limit_reading,
               got.current_limit_reading);
    flag_field("power_limit_reading", want.power_limit_reading, got.power_limit_reading);
    flag_field("status_reading", want.status_reading, got.status_reading);
    flag_field("poll_request", 16'(want.poll_request), 16'(got.poll_request));
    flag_field("timed_out", 16'(want.timed_out), 16'(got.timed_out));
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents the next queued word; a word is taken at an edge with
  // valid high and stall low. Valid is only lowered once a word is taken.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) track_status_line(in_word_i);
      if (!in_valid_i || !in_stall_o) begin
        if (tx_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word_i  <= tx_words.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor / receiver: checks each taken result word. Every HoldEvery
  // results it holds stall for a long stretch so the output and skid
  // registers fill and the block back-pressures the sender.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        compare_report(out_word_o);
        reports_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (reports_seen >= next_hold_at) begin
        hold_left    = HoldCycles;
        next_hold_at = next_hold_at + HoldEvery;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    in_word_t w;
    w.item_kind  = KindByte;
    w.byte_value = b;
    tx_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_ticks(input int n);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.item_kind  = KindTick;
      w.byte_value = 8'($urandom_range(255));   // ignored by the block
      tx_words.push_back(w);
      words_queued++;
      ticks_queued++;
    end
  endtask

  // Build one line of len bytes followed by LF. Tags go to their fixed
  // positions when tags_on; a CR goes to cr_at (NoCr or past len = none).
  task automatic push_status_line(input int len, input int cr_at,
                                  input digit_mode_e mode, input bit tags_on);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (mode)
        DigitsNine: b = DigitBase + 8'd9;
        DigitsZero: b = DigitBase;
        DigitsNul:  b = 8'h00;
        DigitsFF:   b = 8'hFF;
        DigitsAny:  b = 8'($urandom_range(255));
        default:    b = DigitBase + 8'($urandom_range(9));
      endcase
      if (tags_on) begin
        case (i)
          PosVolt: b = TagVolt;
          PosCurr: b = TagCurr;
          PosVLim: b = TagVLim;
          PosILim: b = TagILim;
          PosPLim: b = TagPLim;
          PosStat: b = TagStat;
          default: ;
        endcase
      end
      if (i == cr_at) b = CrChar;
      push_byte(b);
    end
    push_byte(LfChar);
  endtask

  // Wait until every queued word is taken and every result has come back,
  // then give the block a few more cycles (bytes leave no result behind).
  task automatic drain_block();
    while (tx_words.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; lands at the end of the access cycle.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == TimeoutAddr) timeout_cfg = data[15:0];
    @(posedge clk_i);
  endtask

  // Random traffic: mostly well-formed lines with random content, plus
  // broken lines, tick bursts and raw noise. Runs until enough words and ticks.
  task automatic run_random_traffic();
    int start_words;
    int start_ticks;
    int pick;
    int cr;
    start_words = words_queued;
    start_ticks = ticks_queued;
    while (words_queued - start_words < 30 || ticks_queued - start_ticks < 2) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        cr = $urandom_range(PosCrB, PosCrA);
        push_status_line(cr + 1, cr,
                         ($urandom_range(3) != 0) ? DigitsRandom
                                                  : digit_mode_e'($urandom_range(5)),
                         1'b1);
        push_ticks($urandom_range(2));   // no tick: next line overwrites a pending one
      end else if (pick < 70) begin
        cr = ($urandom_range(9) < 3) ? $urandom_range(PosCrB, PosCrA) : $urandom_range(60);
        push_status_line($urandom_range(60), cr, digit_mode_e'($urandom_range(5)),
                         1'($urandom_range(1)));
        push_ticks($urandom_range(1));
      end else if (pick < 88) begin
        push_ticks($urandom_range(5, 1));
      end else begin
        repeat ($urandom_range(12, 1)) push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset timeout still in force.
    push_ticks(4);                                            // idle ticks, fill under hold
    push_status_line(PosCrA + 1, PosCrA, DigitsNine, 1'b1);   // largest digits
    push_ticks(1);
    push_status_line(ShortLen, NoCr, DigitsNul, 1'b1);        // wrap low, CR from old tail
    push_ticks(1);
    push_status_line(ShortLen, NoCr, DigitsFF, 1'b1);         // digit bytes wrap high
    push_ticks(1);
    push_status_line(ShortLen, NoCr, DigitsRandom, 1'b0);     // no tags: no update
    push_ticks(1);
    push_status_line(PosCrB + 1, NoCr, DigitsRandom, 1'b1);   // no CR: no update
    push_ticks(1);
    push_status_line(50, PosCrB, DigitsRandom, 1'b1);         // overruns the store
    push_ticks(1);
    push_status_line(6, NoCr, DigitsRandom, 1'b1);            // short line on stale tail
    push_ticks(1);
    push_status_line(12, NoCr, DigitsRandom, 1'b1);
    repeat (5) push_byte(8'($urandom_range(255, 32)));       // bytes while line pending
    push_ticks(1);
    push_byte(LfChar);                                         // bare LF
    push_ticks(2);
    drain_block();

    // Short timeout, sender 29 / receiver 54 percent idle.
    apb_write(TimeoutAddr, 32'd2);
    apb_write(UnusedAddr, 32'h0000_0001);                     // no such register
    push_ticks(4);
    run_random_traffic();
    drain_block();

    // Idling swapped; timeout of zero times out every idle tick.
    send_idle_pct = 54;
    recv_idle_pct = 29;
    apb_write(TimeoutAddr, 32'd0);
    run_random_traffic();
    drain_block();
    apb_write(TimeoutAddr, 32'd1);
    push_ticks(3);
    drain_block();

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(TimeoutAddr, 32'd7);
    run_random_traffic();
    drain_block();

    // Largest timeout: upper bits of the write are dropped, no timeout here.
    apb_write(TimeoutAddr, 32'hFFFF_FFFF);
    push_ticks(3);
    drain_block();

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #100us;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
